@@ rtl/rau_pkg.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Operation and error codes, controller commands and datapath status.
// ----------------------------------------------------------------------------
package rau_pkg;

   localparam int WIDE_BITS = 64;

   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_DIV = 3'd3;
   localparam logic [2:0] OP_MOD = 3'd4;
   localparam logic [2:0] OP_CMP = 3'd5;

   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_DIV0   = 2'd1;
   localparam logic [1:0] ERR_NONINT = 2'd2;
   localparam logic [1:0] ERR_OVF    = 2'd3;

   localparam logic [1:0] MUL_FIRST  = 2'd0;
   localparam logic [1:0] MUL_SECOND = 2'd1;
   localparam logic [1:0] MUL_THIRD  = 2'd2;

   typedef struct packed {
      logic       load;
      logic       mul_en;
      logic [1:0] mul_idx;
      logic       form;
      logic       gcd_step;
      logic       div_load_num;
      logic       div_load_den;
      logic       div_step;
      logic       stage_arith;
      logic       stage_mod;
      logic       publish;
   } cmd_type;

   typedef struct packed {
      logic early;
      logic is_mod;
      logic gcd_done;
   } sts_type;

endpackage

@@ rtl/rau_controller.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic unit controller
// Sequences products, GCD, the two reducing divisions or the modulo division, and the result handoff.
// ----------------------------------------------------------------------------
module rau_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  rau_pkg::sts_type  sts,
   output rau_pkg::cmd_type  cmd
);
   import rau_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_MUL1  = 4'd1;
   localparam logic [3:0] S_MUL2  = 4'd2;
   localparam logic [3:0] S_MUL3  = 4'd3;
   localparam logic [3:0] S_FORM  = 4'd4;
   localparam logic [3:0] S_GCD   = 4'd5;
   localparam logic [3:0] S_DIVN  = 4'd6;
   localparam logic [3:0] S_LOADD = 4'd7;
   localparam logic [3:0] S_DIVD  = 4'd8;
   localparam logic [3:0] S_FINA  = 4'd9;
   localparam logic [3:0] S_DIVM  = 4'd10;
   localparam logic [3:0] S_FINM  = 4'd11;
   localparam logic [3:0] S_DONE  = 4'd12;

   logic [3:0] state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic       valid_ff, valid_in;
   logic       last_step;

   assign last_step = (cnt_ff == 6'h3f);
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      valid_in = valid_ff & ~rsp_ready;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_idx = MUL_FIRST;
            state_in    = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_idx = MUL_SECOND;
            state_in    = S_MUL3;
         end
         S_MUL3: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_idx = MUL_THIRD;
            state_in    = S_FORM;
         end
         S_FORM: begin
            cmd.form = 1'b1;
            cnt_in   = '0;
            if (sts.early) begin
               state_in = S_DONE;
            end else if (sts.is_mod) begin
               state_in = S_DIVM;
            end else begin
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            cnt_in = '0;
            if (sts.gcd_done) begin
               cmd.div_load_num = 1'b1;
               state_in         = S_DIVN;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         S_DIVN: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 6'd1;
            if (last_step) begin
               state_in = S_LOADD;
            end
         end
         S_LOADD: begin
            cmd.div_load_den = 1'b1;
            cnt_in           = '0;
            state_in         = S_DIVD;
         end
         S_DIVD: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 6'd1;
            if (last_step) begin
               state_in = S_FINA;
            end
         end
         S_FINA: begin
            cmd.stage_arith = 1'b1;
            state_in        = S_DONE;
         end
         S_DIVM: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 6'd1;
            if (last_step) begin
               state_in = S_FINM;
            end
         end
         S_FINM: begin
            cmd.stage_mod = 1'b1;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (!valid_ff || rsp_ready) begin
               cmd.publish = 1'b1;
               valid_in    = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

endmodule

@@ rtl/rau_datapath.sv @@
// ----------------------------------------------------------------------------
// Rational arithmetic unit datapath
// Shared multiplier, binary GCD unit, restoring divider and result registers.
// ----------------------------------------------------------------------------
module rau_datapath #(
   parameter int WORD_BITS = 32
) (
   input  logic                clock,
   input  rau_pkg::cmd_type    cmd,
   output rau_pkg::sts_type    sts,
   input  logic [2:0]          req_operation,
   input  logic signed [31:0]  req_a_num,
   input  logic [30:0]         req_a_den,
   input  logic signed [31:0]  req_b_num,
   input  logic [30:0]         req_b_den,
   output logic signed [31:0]  rsp_res_num,
   output logic [30:0]         rsp_res_den,
   output logic                rsp_is_integer,
   output logic signed [1:0]   rsp_order,
   output logic [1:0]          rsp_error
);
   import rau_pkg::*;

   logic [2:0]          op_ff;
   logic signed [31:0]  an_ff, bn_ff;
   logic [30:0]         ad_ff, bd_ff;
   logic signed [63:0]  p1_ff, p2_ff, p3_ff;
   logic                neg_ff;
   logic [63:0]         mag_ff, uden_ff;
   logic [63:0]         ga_ff, gb_ff, g_ff;
   logic [5:0]          k_ff;
   logic [63:0]         rem_ff, quo_ff, dvs_ff;
   logic signed [31:0]  st_num_ff, out_num_ff;
   logic [30:0]         st_den_ff, out_den_ff;
   logic                st_int_ff, out_int_ff;
   logic signed [1:0]   st_ord_ff, out_ord_ff;
   logic [1:0]          st_err_ff, out_err_ff;

   logic signed [32:0]  mul_x, mul_y;
   logic signed [65:0]  prod;
   logic signed [64:0]  num_w, num_n, den_n;
   logic                den_neg, neg_w;
   logic [63:0]         mag_w, uden_w;
   logic                early;
   logic signed [1:0]   early_ord;
   logic [1:0]          early_err;
   logic [63:0]         ga_in, gb_in, g_val, gbase;
   logic [5:0]          k_in;
   logic [64:0]         div_t, div_d;
   logic                div_ge;
   logic [63:0]         lim, an_mag;
   logic                ovf;
   logic [31:0]         mag32, rem32;

   // Shared multiplier, one product per cycle.
   always_comb begin
      mul_x = {an_ff[31], an_ff};
      mul_y = {2'b00, bd_ff};
      case (cmd.mul_idx)
         MUL_FIRST: begin
            mul_x = {an_ff[31], an_ff};
            mul_y = (op_ff == OP_MUL) ? {bn_ff[31], bn_ff} : {2'b00, bd_ff};
         end
         MUL_SECOND: begin
            mul_x = {bn_ff[31], bn_ff};
            mul_y = {2'b00, ad_ff};
         end
         MUL_THIRD: begin
            mul_x = (op_ff == OP_DIV) ? {bn_ff[31], bn_ff} : {2'b00, bd_ff};
            mul_y = {2'b00, ad_ff};
         end
         default: begin
            mul_x = {an_ff[31], an_ff};
            mul_y = {2'b00, bd_ff};
         end
      endcase
   end

   assign prod = mul_x * mul_y;

   // Numerator and denominator with the sign moved to the numerator.
   always_comb begin
      case (op_ff)
         OP_ADD:  num_w = 65'(p1_ff) + 65'(p2_ff);
         OP_SUB:  num_w = 65'(p1_ff) - 65'(p2_ff);
         default: num_w = 65'(p1_ff);
      endcase
      den_neg = p3_ff[63];
      num_n   = den_neg ? -num_w : num_w;
      den_n   = den_neg ? -65'(p3_ff) : 65'(p3_ff);
      neg_w   = num_n[64];
      mag_w   = neg_w ? 64'(-num_n) : num_n[63:0];
      uden_w  = den_n[63:0];
   end

   // Cases settled without reduction.
   always_comb begin
      early     = 1'b1;
      early_err = ERR_NONE;
      early_ord = 2'sd0;
      if (op_ff > OP_CMP) begin
         early_err = ERR_NONE;
      end else if (ad_ff == '0 || bd_ff == '0) begin
         early_err = ERR_DIV0;
      end else if (op_ff == OP_DIV && bn_ff == '0) begin
         early_err = ERR_DIV0;
      end else if (op_ff == OP_MOD && (ad_ff != 31'd1 || bd_ff != 31'd1)) begin
         early_err = ERR_NONINT;
      end else if (op_ff == OP_MOD && bn_ff == '0) begin
         early_err = ERR_DIV0;
      end else if (op_ff == OP_CMP) begin
         if (p1_ff < p2_ff) begin
            early_ord = -2'sd1;
         end else if (p1_ff > p2_ff) begin
            early_ord = 2'sd1;
         end
      end else begin
         early = 1'b0;
      end
   end

   // One binary GCD step.
   always_comb begin
      ga_in = ga_ff;
      gb_in = gb_ff;
      k_in  = k_ff;
      if (!ga_ff[0] && !gb_ff[0]) begin
         ga_in = ga_ff >> 1;
         gb_in = gb_ff >> 1;
         k_in  = k_ff + 6'd1;
      end else if (!ga_ff[0]) begin
         ga_in = ga_ff >> 1;
      end else if (!gb_ff[0]) begin
         gb_in = gb_ff >> 1;
      end else if (ga_ff >= gb_ff) begin
         ga_in = ga_ff - gb_ff;
      end else begin
         gb_in = gb_ff - ga_ff;
      end
   end

   assign gbase = (ga_ff == '0) ? gb_ff : ga_ff;
   assign g_val = gbase << k_ff;

   assign sts.early    = early;
   assign sts.is_mod   = (op_ff == OP_MOD);
   assign sts.gcd_done = (ga_ff == '0) || (gb_ff == '0);

   // Restoring divider step.
   assign div_t  = {rem_ff, quo_ff[63]};
   assign div_d  = {1'b0, dvs_ff};
   assign div_ge = (div_t >= div_d);

   assign an_mag = an_ff[31] ? 64'(-65'(an_ff)) : 64'(an_ff);

   assign lim   = 64'd1 << (WORD_BITS - 1);
   assign ovf   = (quo_ff > lim - 64'd1) ||
                  (neg_ff ? (mag_ff > lim) : (mag_ff > lim - 64'd1));
   assign mag32 = mag_ff[31:0];
   assign rem32 = rem_ff[31:0];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_operation;
         an_ff <= req_a_num;
         ad_ff <= req_a_den;
         bn_ff <= req_b_num;
         bd_ff <= req_b_den;
      end
      if (cmd.mul_en) begin
         case (cmd.mul_idx)
            MUL_FIRST:  p1_ff <= prod[63:0];
            MUL_SECOND: p2_ff <= prod[63:0];
            default:    p3_ff <= prod[63:0];
         endcase
      end
      if (cmd.form) begin
         neg_ff    <= neg_w;
         mag_ff    <= mag_w;
         uden_ff   <= uden_w;
         ga_ff     <= mag_w;
         gb_ff     <= uden_w;
         k_ff      <= '0;
         quo_ff    <= an_mag;
         rem_ff    <= '0;
         dvs_ff    <= 64'(bn_ff[31] ? -33'(bn_ff) : 33'(bn_ff));
         st_num_ff <= '0;
         st_den_ff <= 31'd1;
         st_int_ff <= 1'b0;
         st_ord_ff <= early_ord;
         st_err_ff <= early_err;
      end
      if (cmd.gcd_step) begin
         ga_ff <= ga_in;
         gb_ff <= gb_in;
         k_ff  <= k_in;
      end
      if (cmd.div_load_num) begin
         g_ff   <= g_val;
         quo_ff <= mag_ff;
         rem_ff <= '0;
         dvs_ff <= g_val;
      end
      if (cmd.div_load_den) begin
         mag_ff <= quo_ff;
         quo_ff <= uden_ff;
         rem_ff <= '0;
         dvs_ff <= g_ff;
      end
      if (cmd.div_step) begin
         rem_ff <= div_ge ? 64'(div_t - div_d) : div_t[63:0];
         quo_ff <= {quo_ff[62:0], div_ge};
      end
      if (cmd.stage_arith) begin
         st_ord_ff <= 2'sd0;
         if (ovf) begin
            st_num_ff <= '0;
            st_den_ff <= 31'd1;
            st_int_ff <= 1'b0;
            st_err_ff <= ERR_OVF;
         end else begin
            st_num_ff <= neg_ff ? -mag32 : mag32;
            st_den_ff <= quo_ff[30:0];
            st_int_ff <= (quo_ff == 64'd1);
            st_err_ff <= ERR_NONE;
         end
      end
      if (cmd.stage_mod) begin
         st_num_ff <= an_ff[31] ? -rem32 : rem32;
         st_den_ff <= 31'd1;
         st_int_ff <= 1'b1;
         st_ord_ff <= 2'sd0;
         st_err_ff <= ERR_NONE;
      end
      if (cmd.publish) begin
         out_num_ff <= st_num_ff;
         out_den_ff <= st_den_ff;
         out_int_ff <= st_int_ff;
         out_ord_ff <= st_ord_ff;
         out_err_ff <= st_err_ff;
      end
   end

   assign rsp_res_num    = out_num_ff;
   assign rsp_res_den    = out_den_ff;
   assign rsp_is_integer = out_int_ff;
   assign rsp_order      = out_ord_ff;
   assign rsp_error      = out_err_ff;

endmodule

@@ rtl/rational_arithmetic_unit.sv @@
// Compare, errors and unused codes finish without reduction; modulo takes one
// restoring division; add, subtract, multiply and divide take three products
// on the shared multiplier, binary GCD steps and two restoring divisions.
// One item is in flight at a time; a finished result waits in the output
// register while the next item is accepted.
// Synchronous active-high reset clears the controller and the output valid.
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Exact add, subtract, multiply, divide, modulo and compare of rationals.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
   parameter int WORD_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_operation,
   input  logic signed [31:0] req_a_num,
   input  logic [30:0]        req_a_den,
   input  logic signed [31:0] req_b_num,
   input  logic [30:0]        req_b_den,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_res_num,
   output logic [30:0]        rsp_res_den,
   output logic               rsp_is_integer,
   output logic signed [1:0]  rsp_order,
   output logic [1:0]         rsp_error
);
   import rau_pkg::*;

   cmd_type cmd;
   sts_type sts;

   rau_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rau_datapath #(
      .WORD_BITS (WORD_BITS)
   ) u_dp (
      .clock          (clock),
      .cmd            (cmd),
      .sts            (sts),
      .req_operation  (req_operation),
      .req_a_num      (req_a_num),
      .req_a_den      (req_a_den),
      .req_b_num      (req_b_num),
      .req_b_den      (req_b_den),
      .rsp_res_num    (rsp_res_num),
      .rsp_res_den    (rsp_res_den),
      .rsp_is_integer (rsp_is_integer),
      .rsp_order      (rsp_order),
      .rsp_error      (rsp_error)
   );

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error != ERR_NONE |-> rsp_res_num == 0 && rsp_res_den == 31'd1)
      else $error("error result is not zero over one");

   a_int_den: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_integer |-> rsp_res_den == 31'd1)
      else $error("integer flag with denominator other than one");

   a_order_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_order != 2'sd0 |-> rsp_error == ERR_NONE && !rsp_is_integer)
      else $error("compare result with error or integer flag");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("new item accepted while one is in flight");

endmodule
